>>> rtl/stup_pkg.sv
package stup_pkg;

  // text offset saturation point
  localparam int unsigned OffsetLimit = 4095;
  localparam int unsigned OffW = 12;
  localparam logic [OffW-1:0] OFF_CAP =
    (OffsetLimit < 4095) ? OffW'(OffsetLimit) : 12'd4095;

  localparam logic [1:0] PROG_NONE   = 2'd0;
  localparam logic [1:0] PROG_DIGITS = 2'd1;
  localparam logic [1:0] PROG_OVF    = 2'd2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_MIN  = 6'd2;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_MAX  = 6'd36;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic       start_req;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [63:0]     value;
    logic            overflowed;
    logic            any_digits;
    logic [OffW-1:0] end_offset;
  } out_item_t;

  typedef struct packed {
    phase_t          phase;
    logic            negative;
    logic [1:0]      progress;
    logic [63:0]     acc;
    logic [5:0]      active_base;
    logic [OffW-1:0] byte_count;
  } parse_state_t;

  localparam parse_state_t STATE_INIT = '{
    phase: PH_SPACE, negative: 1'b0, progress: PROG_NONE,
    acc: 64'd0, active_base: 6'd0, byte_count: '0
  };

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } digit_t;

  function automatic logic [OffW-1:0] sat_next(input logic [OffW-1:0] idx);
    sat_next = (idx >= OFF_CAP) ? OFF_CAP : idx + OffW'(1);
  endfunction

  function automatic digit_t digit_of(input logic [7:0] c);
    digit_t     d;
    logic [7:0] t;
    d = '{ok: 1'b0, val: 6'd0};
    t = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      d = '{ok: 1'b1, val: t[5:0]};
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - CH_UA + 8'd10;
      d = '{ok: 1'b1, val: t[5:0]};
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - CH_LA + 8'd10;
      d = '{ok: 1'b1, val: t[5:0]};
    end
    digit_of = d;
  endfunction

endpackage

>>> rtl/stup_step.sv
module stup_step (
  input  stup_pkg::parse_state_t cur_state,
  input  stup_pkg::in_item_t     item,
  input  logic [5:0]             number_base,
  output stup_pkg::parse_state_t state_nxt,
  output logic                   res_valid,
  output stup_pkg::out_item_t    res
);

  stup_pkg::parse_state_t s;
  logic [7:0]             c;
  logic [stup_pkg::OffW-1:0] idx;
  logic                   is_ws;
  logic                   is_sign;
  logic                   is_x;
  logic                   auto_or_hex;
  stup_pkg::digit_t       dg;
  logic                   use_td;
  logic [63:0]            td_acc;
  logic [1:0]             td_prog;
  logic [5:0]             td_base;
  logic                   td_bad;
  logic [69:0]            prod;
  logic                   fin;
  logic [63:0]            fin_acc;
  logic [1:0]             fin_prog;
  logic [stup_pkg::OffW-1:0] fin_off;

  always_comb begin
    s = item.start_req ? stup_pkg::STATE_INIT : cur_state;
    c = item.char_code;
    dg = stup_pkg::digit_of(c);
    idx = (s.phase == stup_pkg::PH_PREFIX) ? stup_pkg::sat_next(s.byte_count)
                                           : s.byte_count;
    is_ws = (c == stup_pkg::CH_SPACE) || (c >= stup_pkg::CH_TAB && c <= stup_pkg::CH_CR);
    is_sign = (c == stup_pkg::CH_PLUS) || (c == stup_pkg::CH_MINUS);
    is_x = (c == stup_pkg::CH_LX) || (c == stup_pkg::CH_UX);
    auto_or_hex = (number_base == stup_pkg::BASE_AUTO) ||
                  (number_base == stup_pkg::BASE_HEX);

    state_nxt = s;
    use_td = 1'b0;
    td_acc = s.acc;
    td_prog = s.progress;
    td_base = s.active_base;
    fin = 1'b0;
    fin_acc = s.acc;
    fin_prog = s.progress;
    fin_off = idx;

    unique case (s.phase)
      stup_pkg::PH_SPACE, stup_pkg::PH_SIGNED: begin
        if (s.phase == stup_pkg::PH_SPACE && is_ws) begin
          state_nxt.byte_count = stup_pkg::sat_next(idx);
        end else if (s.phase == stup_pkg::PH_SPACE && is_sign) begin
          state_nxt.negative = (c == stup_pkg::CH_MINUS);
          state_nxt.phase = stup_pkg::PH_SIGNED;
          state_nxt.byte_count = stup_pkg::sat_next(idx);
        end else if (auto_or_hex && c == stup_pkg::CH_ZERO) begin
          state_nxt.progress = stup_pkg::PROG_DIGITS;
          state_nxt.acc = 64'd0;
          state_nxt.phase = stup_pkg::PH_ZERO;
          state_nxt.byte_count = stup_pkg::sat_next(idx);
        end else begin
          td_base = (number_base == stup_pkg::BASE_AUTO) ? stup_pkg::BASE_DEC
                                                         : number_base;
          state_nxt.active_base = td_base;
          state_nxt.phase = stup_pkg::PH_DIGITS;
          use_td = 1'b1;
        end
      end
      stup_pkg::PH_ZERO: begin
        if (is_x) begin
          state_nxt.phase = stup_pkg::PH_PREFIX;
          state_nxt.byte_count = idx;
        end else begin
          td_base = (number_base == stup_pkg::BASE_AUTO) ? stup_pkg::BASE_OCT
                                                         : stup_pkg::BASE_HEX;
          state_nxt.active_base = td_base;
          state_nxt.phase = stup_pkg::PH_DIGITS;
          use_td = 1'b1;
        end
      end
      stup_pkg::PH_PREFIX: begin
        state_nxt.active_base = stup_pkg::BASE_HEX;
        state_nxt.acc = 64'd0;
        state_nxt.progress = stup_pkg::PROG_DIGITS;
        td_acc = 64'd0;
        td_prog = stup_pkg::PROG_DIGITS;
        td_base = stup_pkg::BASE_HEX;
        if (dg.ok && dg.val < stup_pkg::BASE_HEX) begin
          state_nxt.phase = stup_pkg::PH_DIGITS;
          use_td = 1'b1;
        end else begin
          // "0x" with no hex digit after it: only the zero counts
          fin = 1'b1;
          fin_acc = 64'd0;
          fin_prog = stup_pkg::PROG_DIGITS;
          fin_off = s.byte_count;
        end
      end
      stup_pkg::PH_DIGITS: begin
        use_td = 1'b1;
      end
      default: begin
      end
    endcase

    // one digit step: acc * base + digit, saturate on carry out of 64 bits
    td_bad = (td_base < stup_pkg::BASE_MIN) || (td_base > stup_pkg::BASE_MAX) ||
             !dg.ok || (dg.val >= td_base);
    prod = 70'(td_acc) * 70'(td_base) + 70'(dg.val);

    if (use_td) begin
      if (td_bad) begin
        fin = 1'b1;
        fin_acc = td_acc;
        fin_prog = td_prog;
        fin_off = idx;
      end else begin
        if (td_prog != stup_pkg::PROG_OVF) begin
          if (|prod[69:64]) begin
            state_nxt.progress = stup_pkg::PROG_OVF;
            state_nxt.acc = '1;
          end else begin
            state_nxt.progress = stup_pkg::PROG_DIGITS;
            state_nxt.acc = prod[63:0];
          end
        end
        state_nxt.byte_count = stup_pkg::sat_next(idx);
      end
    end

    if (fin) begin
      state_nxt.phase = stup_pkg::PH_DONE;
    end
    res_valid = fin;

    if (fin_prog == stup_pkg::PROG_OVF) begin
      res.value = '1;
    end else if (s.negative && fin_prog == stup_pkg::PROG_DIGITS) begin
      res.value = 64'd0 - fin_acc;
    end else begin
      res.value = fin_acc;
    end
    res.overflowed = (fin_prog == stup_pkg::PROG_OVF);
    res.any_digits = (fin_prog != stup_pkg::PROG_NONE);
    res.end_offset = (fin_prog != stup_pkg::PROG_NONE) ? fin_off : '0;
  end

endmodule

>>> rtl/string_to_unsigned_parser_core.sv
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_stall   | stup_pkg::in_item_t (start_req, char_code)
// out_    | output    | out_valid / out_stall | stup_pkg::out_item_t (value, flags, offset)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_data, 6-bit number_base
//
// one item per cycle while in_stall is low; an item is registered on acceptance, parsed
// in the next cycle by one 64x6 multiply-add and compare, and its result lands in the
// output register, whose valid flag drives out_valid
// rst_n is synchronous, active low; it clears the parse state, base and both valids
// out_stall holds the result register; the input register still drains items that
// give no result, and in_stall rises only when a finishing item finds the result full
module string_to_unsigned_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stup_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stup_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);

  // input register
  logic                   in_v_r;
  stup_pkg::in_item_t     in_r;

  // parse state and configured radix
  stup_pkg::parse_state_t state_r;
  stup_pkg::parse_state_t state_nxt;
  logic [5:0]             base_r;

  // result register
  logic                   out_v_r;
  stup_pkg::out_item_t    out_r;

  logic                   res_valid;
  stup_pkg::out_item_t    res;
  logic                   out_free;
  logic                   fire;

  stup_step u_step (
    .cur_state   (state_r),
    .item        (in_r),
    .number_base (base_r),
    .state_nxt   (state_nxt),
    .res_valid   (res_valid),
    .res         (res)
  );

  // an item without a result never waits on the output side
  assign out_free  = !out_v_r || !out_stall;
  assign fire      = in_v_r && (!res_valid || out_free);
  assign in_stall  = in_v_r && !fire;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stup_pkg::STATE_INIT;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= stup_pkg::BASE_AUTO;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire && res_valid) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

`ifndef NO_ASSERTIONS
  // a finishing item parks the parser until the next start
  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |=> state_r.phase == stup_pkg::PH_DONE)
    else $error("parser not parked after result");

  // saturation always shows as all ones
  a_ovf_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.overflowed |-> (&out_r.value) && out_r.any_digits)
    else $error("overflow without saturated value");

  // no digits means a clean zero result
  a_no_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.any_digits |-> out_r.value == 64'd0 && out_r.end_offset == '0)
    else $error("empty parse with nonzero fields");

  // backpressure only comes from a finishing item meeting a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r && res_valid && out_v_r && out_stall)
    else $error("input stalled without output backpressure");
`endif

endmodule
